FILE: rtl/tcc_pkg.sv
// Shared types, constants and codes of the tour cycle checker.
`default_nettype none

package tcc_pkg;

  localparam int NodeW     = 7;
  localparam int WeightInW = 16;
  localparam int DistW     = 30;
  localparam int PathNumW  = 16;
  localparam int BestDistW = 31;
  localparam int VerdictW  = 2;

  localparam int MaxNodesDefault   = 64;
  localparam int WeightBitsDefault = 16;

  localparam logic [NodeW-1:0]     NodeCountReset = 7'd64;
  localparam logic [DistW-1:0]     DistMax        = {DistW{1'b1}};
  localparam logic [BestDistW-1:0] NoBest         = {1'b1, {DistW{1'b0}}};

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_VERTEX = 1'b1;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_NONE   = 2'd0,
    VERDICT_SIMPLE = 2'd1,
    VERDICT_TOUR   = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // One path vertex handed from the sequencer to the path tracker.
  typedef struct packed {
    logic             fire;
    logic [NodeW-1:0] vertex;
    logic             last;
    logic             in_range;
    logic             edge_usable;
  } step_t;

  typedef struct packed {
    logic             in_path;
    logic [NodeW-1:0] prev_vertex;
    logic             out_free;
  } path_status_t;

endpackage

`default_nettype wire

FILE: rtl/tcc_cfg_if.sv
// Configuration write channel carrying the node count.
`default_nettype none

interface tcc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tcc_pkg::NodeW-1:0] node_count;

  modport source (output valid, output node_count, input ready);
  modport sink (input valid, input node_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcc_in_if.sv
// Input channel carrying edge loads and path vertices.
`default_nettype none

interface tcc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [tcc_pkg::NodeW-1:0]     node_a;
  logic [tcc_pkg::NodeW-1:0]     node_b;
  logic [tcc_pkg::WeightInW-1:0] weight;
  logic                          last;

  modport source (output valid, output cmd, output node_a, output node_b,
                  output weight, output last, input ready);
  modport sink (input valid, input cmd, input node_a, input node_b,
                input weight, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcc_out_if.sv
// Result channel carrying the verdict of a finished path.
`default_nettype none

interface tcc_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcc_pkg::PathNumW-1:0]  path_number;
  logic [tcc_pkg::DistW-1:0]     distance;
  logic                          edges_present;
  logic [tcc_pkg::VerdictW-1:0]  verdict;
  logic [tcc_pkg::PathNumW-1:0]  best_path;
  logic [tcc_pkg::BestDistW-1:0] best_distance;

  modport source (output valid, output path_number, output distance,
                  output edges_present, output verdict, output best_path,
                  output best_distance, input ready);
  modport sink (input valid, input path_number, input distance,
                input edges_present, input verdict, input best_path,
                input best_distance, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tcc_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/tcc_path.sv
// Path tracker: visit masks, running distance, verdict, best tour and result register.
`default_nettype none

module tcc_path #(
  parameter int MaxNodes   = tcc_pkg::MaxNodesDefault,
  parameter int WeightBits = tcc_pkg::WeightBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcc_pkg::step_t                    step_i,
  input  logic [$clog2(MaxNodes+1)-1:0]     n_use_i,
  input  logic [WeightBits-1:0]             edge_weight_i,
  output tcc_pkg::path_status_t             status_o,
  tcc_out_if.source                         out_o
);

  localparam int CoordW = $clog2(MaxNodes);
  localparam int CntW   = $clog2(MaxNodes+1);
  localparam int SumW   = (tcc_pkg::DistW > WeightBits ? tcc_pkg::DistW : WeightBits) + 1;

  logic [MaxNodes-1:0]              visited_q, visited_d;
  logic [MaxNodes-1:0]              repeated_q, repeated_d;
  logic [CntW-1:0]                  distinct_q, distinct_d;
  logic [CntW-1:0]                  rep_cnt_q, rep_cnt_d;
  logic [tcc_pkg::DistW-1:0]        dist_q, dist_d;
  logic [tcc_pkg::NodeW-1:0]        first_q, first_d;
  logic [tcc_pkg::NodeW-1:0]        prev_q, prev_d;
  logic                             in_path_q, in_path_d;
  logic                             ok_q, ok_d;
  logic [tcc_pkg::PathNumW-1:0]     count_q, count_d;
  logic [tcc_pkg::PathNumW-1:0]     best_idx_q, best_idx_d;
  logic [tcc_pkg::BestDistW-1:0]    best_len_q, best_len_d;

  logic                             out_valid_q, out_valid_d;
  logic [tcc_pkg::PathNumW-1:0]     out_num_q, out_num_d;
  logic [tcc_pkg::DistW-1:0]        out_dist_q, out_dist_d;
  logic                             out_ok_q, out_ok_d;
  tcc_pkg::verdict_e                out_verdict_q, out_verdict_d;
  logic [tcc_pkg::PathNumW-1:0]     out_best_q, out_best_d;
  logic [tcc_pkg::BestDistW-1:0]    out_best_len_q, out_best_len_d;

  always_comb begin
    logic [CoordW-1:0]         idx;
    logic [WeightBits-1:0]     e;
    logic [SumW-1:0]           sum;
    logic [tcc_pkg::NodeW-1:0] first_upd;
    tcc_pkg::verdict_e         verdict;

    visited_d      = visited_q;
    repeated_d     = repeated_q;
    distinct_d     = distinct_q;
    rep_cnt_d      = rep_cnt_q;
    dist_d         = dist_q;
    first_d        = first_q;
    prev_d         = prev_q;
    in_path_d      = in_path_q;
    ok_d           = ok_q;
    count_d        = count_q;
    best_idx_d     = best_idx_q;
    best_len_d     = best_len_q;
    out_num_d      = out_num_q;
    out_dist_d     = out_dist_q;
    out_ok_d       = out_ok_q;
    out_verdict_d  = out_verdict_q;
    out_best_d     = out_best_q;
    out_best_len_d = out_best_len_q;
    out_valid_d    = out_valid_q && !out_o.ready;

    idx       = CoordW'(step_i.vertex - tcc_pkg::NodeW'(1));
    e         = step_i.edge_usable ? edge_weight_i : '0;
    sum       = SumW'(dist_q) + SumW'(e);
    first_upd = in_path_q ? first_q : step_i.vertex;
    verdict   = tcc_pkg::VERDICT_NONE;

    if (step_i.fire) begin
      if (step_i.in_range) begin
        if (visited_q[idx]) begin
          if (!repeated_q[idx]) begin
            repeated_d[idx] = 1'b1;
            rep_cnt_d       = rep_cnt_q + CntW'(1);
          end
        end else begin
          visited_d[idx] = 1'b1;
          distinct_d     = distinct_q + CntW'(1);
        end
      end else begin
        ok_d = 1'b0;
      end

      if (!in_path_q) begin
        first_d   = step_i.vertex;
        in_path_d = 1'b1;
      end else if (e != '0) begin
        dist_d = (sum > SumW'(tcc_pkg::DistMax)) ? tcc_pkg::DistMax
                                                  : tcc_pkg::DistW'(sum);
      end else begin
        ok_d = 1'b0;
      end
      prev_d = step_i.vertex;

      if (step_i.last) begin
        count_d = count_q + tcc_pkg::PathNumW'(1);
        if (!ok_d || distinct_d != n_use_i || first_upd != step_i.vertex) begin
          verdict = tcc_pkg::VERDICT_NONE;
        end else if (rep_cnt_d == CntW'(1)) begin
          verdict = tcc_pkg::VERDICT_SIMPLE;
        end else begin
          verdict = tcc_pkg::VERDICT_TOUR;
        end
        // Only a strictly shorter accepted tour displaces the best one.
        if (verdict != tcc_pkg::VERDICT_NONE &&
            tcc_pkg::BestDistW'(dist_d) < best_len_q) begin
          best_len_d = tcc_pkg::BestDistW'(dist_d);
          best_idx_d = count_d;
        end

        out_valid_d    = 1'b1;
        out_num_d      = count_d;
        out_dist_d     = dist_d;
        out_ok_d       = ok_d;
        out_verdict_d  = verdict;
        out_best_d     = best_idx_d;
        out_best_len_d = best_len_d;

        visited_d  = '0;
        repeated_d = '0;
        distinct_d = '0;
        rep_cnt_d  = '0;
        dist_d     = '0;
        first_d    = '0;
        prev_d     = '0;
        in_path_d  = 1'b0;
        ok_d       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q   <= '0;
      repeated_q  <= '0;
      distinct_q  <= '0;
      rep_cnt_q   <= '0;
      dist_q      <= '0;
      first_q     <= '0;
      prev_q      <= '0;
      in_path_q   <= 1'b0;
      ok_q        <= 1'b1;
      count_q     <= '0;
      best_idx_q  <= '0;
      best_len_q  <= tcc_pkg::NoBest;
      out_valid_q <= 1'b0;
    end else begin
      visited_q   <= visited_d;
      repeated_q  <= repeated_d;
      distinct_q  <= distinct_d;
      rep_cnt_q   <= rep_cnt_d;
      dist_q      <= dist_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      in_path_q   <= in_path_d;
      ok_q        <= ok_d;
      count_q     <= count_d;
      best_idx_q  <= best_idx_d;
      best_len_q  <= best_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_num_q      <= out_num_d;
    out_dist_q     <= out_dist_d;
    out_ok_q       <= out_ok_d;
    out_verdict_q  <= out_verdict_d;
    out_best_q     <= out_best_d;
    out_best_len_q <= out_best_len_d;
  end

  assign status_o.in_path     = in_path_q;
  assign status_o.prev_vertex = prev_q;
  assign status_o.out_free    = !out_valid_q || out_o.ready;

  assign out_o.valid         = out_valid_q;
  assign out_o.path_number   = out_num_q;
  assign out_o.distance      = out_dist_q;
  assign out_o.edges_present = out_ok_q;
  assign out_o.verdict       = out_verdict_q;
  assign out_o.best_path     = out_best_q;
  assign out_o.best_distance = out_best_len_q;

endmodule

`default_nettype wire

FILE: rtl/tour_cycle_checker.sv
// Top level of the tour cycle checker: sequencer, weight memory and path tracker.
`default_nettype none

// Edge loads and path vertices arrive on in_i. An edge load with both endpoints
// in range writes a single entry of the weight memory, which keeps only one
// triangle of the symmetric matrix (row is the smaller endpoint). A path vertex
// first reads the weight between the previous and the current vertex from the
// memory and then updates the path tracker; the last vertex of a path
// additionally waits while an earlier result still sits unclaimed in the
// output register. After reset the weight memory is cleared one entry a cycle,
// all 2^(2*ceil(log2(MaxNodes))) entries (4096 at the default), during which
// in_i is not ready; configuration writes are taken at any time and must only
// be made while no transaction is in flight.
module tour_cycle_checker #(
  parameter int MaxNodes   = tcc_pkg::MaxNodesDefault,
  parameter int WeightBits = tcc_pkg::WeightBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcc_cfg_if.sink   cfg_i,
  tcc_in_if.sink    in_i,
  tcc_out_if.source out_o
);

  localparam int CoordW = $clog2(MaxNodes);
  localparam int AddrW  = 2 * CoordW;
  localparam int Depth  = 1 << AddrW;
  localparam int CntW   = $clog2(MaxNodes+1);

  tcc_pkg::state_e           state_q, state_d;
  logic [AddrW-1:0]          clr_cnt_q, clr_cnt_d;
  logic [tcc_pkg::NodeW-1:0] node_count_q;

  logic [tcc_pkg::NodeW-1:0] vertex_q;
  logic                      last_q;
  logic                      in_range_q;
  logic                      edge_usable_q;

  tcc_pkg::step_t            step;
  tcc_pkg::path_status_t     status;
  logic [CntW-1:0]           n_use;
  logic                      in_accept;
  logic                      is_vertex;
  logic                      vertex_in_range;
  logic                      prev_ok;
  logic                      load_ok;
  logic [tcc_pkg::NodeW-1:0] op_x, op_y, op_lo, op_hi;
  logic [AddrW-1:0]          pair_addr;

  logic                      ram_we, ram_re;
  logic [AddrW-1:0]          ram_waddr;
  logic [WeightBits-1:0]     ram_wdata, ram_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= tcc_pkg::NodeCountReset;
    end else if (cfg_i.valid) begin
      node_count_q <= cfg_i.node_count;
    end
  end

  assign n_use = (32'(node_count_q) > MaxNodes) ? CntW'(MaxNodes) : CntW'(node_count_q);

  assign in_accept       = in_i.valid && in_i.ready;
  assign is_vertex       = in_i.cmd == tcc_pkg::CMD_VERTEX;
  assign vertex_in_range = in_i.node_a != '0 && 32'(in_i.node_a) <= 32'(n_use);
  assign prev_ok         = status.prev_vertex != '0 && 32'(status.prev_vertex) <= MaxNodes;
  assign load_ok         = in_i.node_a != '0 && 32'(in_i.node_a) <= MaxNodes &&
                           in_i.node_b != '0 && 32'(in_i.node_b) <= MaxNodes;

  // Both accesses address the upper triangle: smaller node selects the row.
  assign op_x      = is_vertex ? status.prev_vertex : in_i.node_a;
  assign op_y      = is_vertex ? in_i.node_a : in_i.node_b;
  assign op_lo     = (op_x < op_y) ? op_x : op_y;
  assign op_hi     = (op_x < op_y) ? op_y : op_x;
  assign pair_addr = {CoordW'(op_lo - tcc_pkg::NodeW'(1)),
                      CoordW'(op_hi - tcc_pkg::NodeW'(1))};

  assign step.fire        = state_q == tcc_pkg::ST_EXEC && (!last_q || status.out_free);
  assign step.vertex      = vertex_q;
  assign step.last        = last_q;
  assign step.in_range    = in_range_q;
  assign step.edge_usable = edge_usable_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcc_pkg::ST_CLEAR: begin
        if (clr_cnt_q == AddrW'(Depth - 1)) begin
          state_d = tcc_pkg::ST_IDLE;
        end
      end
      tcc_pkg::ST_IDLE: begin
        if (in_accept && is_vertex) begin
          state_d = tcc_pkg::ST_EXEC;
        end
      end
      tcc_pkg::ST_EXEC: begin
        if (step.fire) begin
          state_d = tcc_pkg::ST_IDLE;
        end
      end
      default: state_d = tcc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pair_addr;
    ram_wdata  = WeightBits'(in_i.weight);
    ram_re     = 1'b0;
    clr_cnt_d  = clr_cnt_q;
    unique case (state_q)
      tcc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AddrW'(1);
      end
      tcc_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_we     = in_accept && !is_vertex && load_ok;
        ram_re     = in_accept && is_vertex;
      end
      tcc_pkg::ST_EXEC: begin
        in_i.ready = 1'b0;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tcc_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // The vertex transaction is held here while its weight is read.
  always_ff @(posedge clk_i) begin
    if (in_accept && is_vertex) begin
      vertex_q      <= in_i.node_a;
      last_q        <= in_i.last;
      in_range_q    <= vertex_in_range;
      edge_usable_q <= status.in_path && vertex_in_range && prev_ok;
    end
  end

  tcc_ram #(
    .Width (WeightBits),
    .Depth (Depth)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pair_addr),
    .rdata_o (ram_rdata)
  );

  tcc_path #(
    .MaxNodes   (MaxNodes),
    .WeightBits (WeightBits)
  ) u_path (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .n_use_i       (n_use),
    .edge_weight_i (ram_rdata),
    .status_o      (status),
    .out_o         (out_o)
  );

endmodule

`default_nettype wire
